// ===== sv/usbpk_pkg.sv =====
`timescale 1ns / 1ps

package usbpk_pkg;

	// Largest payload of one packet, in bytes.
	localparam int MAX_PACKET_BYTES = 8;
	// Width of the in-packet index and of the packet length.
	localparam int IDX_W = $clog2(MAX_PACKET_BYTES + 1);
	// Width of the signed byte and limit counters.
	localparam int CNT_W = 18;
	// Depth of the job queue between the front and the back.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] PID_DATA0_RESET = 8'hC3;
	localparam logic [7:0] PID_DATA1_RESET = 8'h4B;

	// Input commands, carried on the slave-side tuser.
	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_PAYLOAD = 2'd1,
		CMD_ACK     = 2'd2,
		CMD_RX_PID  = 2'd3
	} cmd_t;

	// Kind of a transmitted byte, carried on the master-side tuser.
	typedef enum logic [1:0] {
		KIND_PID     = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_CRC     = 2'd2,
		KIND_REJECT  = 2'd3
	} kind_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_PID_DATA0 = 1'b0,
		REG_PID_DATA1 = 1'b1
	} reg_idx_t;

	// Work handed from the front to the back; each job expands to one to three beats.
	typedef enum logic [2:0] {
		JOB_REJECT   = 3'd0,
		JOB_PID      = 3'd1,
		JOB_ZLP      = 3'd2,
		JOB_PAY      = 3'd3,
		JOB_PAY_LAST = 3'd4
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  data;
		logic [15:0] crc;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ===== sv/usbpk_fifo.sv =====
`timescale 1ns / 1ps

module usbpk_fifo import usbpk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  job_t       push_job,
	input  logic       pop,
	output job_t       head_job,
	output fifo_stat_t stat
);

	job_t                  slots_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

	assign head_job   = slots_q[rd_ptr_q];
	assign stat.full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

// ===== sv/usbpk_front.sv =====
`timescale 1ns / 1ps

module usbpk_front import usbpk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  fifo_stat_t  fifo_stat,
	output logic        push,
	output job_t        push_job
);

	localparam logic signed [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKET_BYTES);

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic [7:0]  d;
		c = crc;
		d = b;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ d[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
			d = d >> 1;
		end
		return c;
	endfunction

	logic [7:0]              pid0_q, pid1_q;
	logic signed [CNT_W-1:0] bl_q, ll_q;
	logic                    active_q, await_q, toggle_q;
	logic [15:0]             crc_q;
	logic [IDX_W-1:0]        idx_q, len_q;

	logic signed [CNT_W-1:0] n_bl, n_ll, len_v;
	logic                    n_active, n_await, n_toggle;
	logic [15:0]             n_crc, crc_v;
	logic [IDX_W-1:0]        n_idx, n_len;
	logic                    prep, job_valid;
	job_t                    job;
	logic [7:0]              pid_v;
	cmd_t                    cmd;
	logic                    accept;

	assign cmd      = cmd_t'(s_tuser);
	assign s_tready = !fifo_stat.full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		n_bl      = bl_q;
		n_ll      = ll_q;
		n_active  = active_q;
		n_await   = await_q;
		n_toggle  = toggle_q;
		n_crc     = crc_q;
		n_idx     = idx_q;
		n_len     = len_q;
		prep      = 1'b0;
		job_valid = 1'b0;
		job.kind  = JOB_REJECT;
		job.data  = 8'h00;
		job.crc   = 16'h0000;
		crc_v     = crc_byte(crc_q, s_tdata[39:32]);
		len_v     = '0;
		pid_v     = 8'h00;

		unique case (cmd)
			CMD_START: begin
				n_bl     = CNT_W'(s_tdata[15:0]);
				n_ll     = CNT_W'(s_tdata[31:16]);
				n_active = 1'b1;
				n_await  = 1'b0;
				n_idx    = '0;
				n_len    = '0;
				n_crc    = CRC_INIT;
				prep     = 1'b1;
			end
			CMD_PAYLOAD: begin
				job_valid = 1'b1;
				if (await_q && (idx_q < len_q)) begin
					n_crc    = crc_v;
					n_idx    = idx_q + IDX_W'(1);
					job.data = s_tdata[39:32];
					job.crc  = ~crc_v;
					job.kind = (n_idx == len_q) ? JOB_PAY_LAST : JOB_PAY;
				end
			end
			CMD_ACK: begin
				if (await_q) begin
					if (idx_q < len_q) begin
						job_valid = 1'b1;
					end else begin
						n_await = 1'b0;
						if (active_q) begin
							n_bl = bl_q - MAX_CNT;
							n_ll = ll_q - MAX_CNT;
						end
						if (n_bl[CNT_W-1] || n_ll[CNT_W-1]) begin
							n_bl     = '0;
							n_ll     = '0;
							n_active = 1'b0;
						end
						prep = 1'b1;
					end
				end
			end
			CMD_RX_PID: begin
				n_toggle = ~s_tdata[40];
				prep     = 1'b1;
			end
		endcase

		// Open the next packet once nothing waits for an ack.
		if (prep && n_active && !n_await) begin
			if ((n_bl == '0) && (n_ll == '0)) begin
				n_active = 1'b0;
			end else begin
				pid_v     = n_toggle ? pid1_q : pid0_q;
				n_toggle  = ~n_toggle;
				job_valid = 1'b1;
				job.data  = pid_v;
				if ((n_bl == '0) || (n_ll == '0)) begin
					n_bl     = '0;
					n_ll     = '0;
					n_active = 1'b0;
					job.kind = JOB_ZLP;
				end else begin
					len_v = (n_bl > MAX_CNT) ? MAX_CNT : n_bl;
					if (len_v > n_ll) begin
						len_v = n_ll;
					end
					n_len    = IDX_W'(len_v);
					n_idx    = '0;
					n_crc    = CRC_INIT;
					n_await  = 1'b1;
					job.kind = JOB_PID;
				end
			end
		end
	end

	assign push     = accept && job_valid;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pid0_q   <= PID_DATA0_RESET;
			pid1_q   <= PID_DATA1_RESET;
			bl_q     <= '0;
			ll_q     <= '0;
			active_q <= 1'b0;
			await_q  <= 1'b0;
			toggle_q <= 1'b0;
			crc_q    <= CRC_INIT;
			idx_q    <= '0;
			len_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_PID_DATA0: pid0_q <= cfg_wdata;
					REG_PID_DATA1: pid1_q <= cfg_wdata;
				endcase
			end
			if (accept) begin
				bl_q     <= n_bl;
				ll_q     <= n_ll;
				active_q <= n_active;
				await_q  <= n_await;
				toggle_q <= n_toggle;
				crc_q    <= n_crc;
				idx_q    <= n_idx;
				len_q    <= n_len;
			end
		end
	end

endmodule

// ===== sv/usbpk_back.sv =====
`timescale 1ns / 1ps

module usbpk_back import usbpk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head_job,
	input  fifo_stat_t fifo_stat,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic [1:0] m_tuser,
	output logic       m_tlast
);

	localparam logic [1:0] STEP_LAST = 2'd2;

	logic [1:0] step_q;
	logic       m_valid_q;
	logic [7:0] m_data_q;
	kind_t      m_kind_q;
	logic       m_last_q;

	logic [7:0] b_data;
	kind_t      b_kind;
	logic       b_last;
	logic       b_done;
	logic       load;

	always_comb begin
		b_data = 8'h00;
		b_kind = KIND_REJECT;
		b_last = 1'b1;
		b_done = 1'b1;
		case (head_job.kind)
			JOB_PID: begin
				b_data = head_job.data;
				b_kind = KIND_PID;
				b_last = 1'b0;
			end
			JOB_PAY: begin
				b_data = head_job.data;
				b_kind = KIND_PAYLOAD;
				b_last = 1'b0;
			end
			JOB_ZLP: begin
				b_done = (step_q == STEP_LAST);
				b_last = (step_q == STEP_LAST);
				if (step_q == '0) begin
					b_data = head_job.data;
					b_kind = KIND_PID;
				end else begin
					b_kind = KIND_CRC;
				end
			end
			JOB_PAY_LAST: begin
				b_done = (step_q == STEP_LAST);
				b_last = (step_q == STEP_LAST);
				if (step_q == '0) begin
					b_data = head_job.data;
					b_kind = KIND_PAYLOAD;
				end else if (step_q == 2'd1) begin
					b_data = head_job.crc[7:0];
					b_kind = KIND_CRC;
				end else begin
					b_data = head_job.crc[15:8];
					b_kind = KIND_CRC;
				end
			end
			default: begin
				b_data = 8'h00;
				b_kind = KIND_REJECT;
				b_last = 1'b1;
			end
		endcase
	end

	assign load = (!m_valid_q || m_tready) && !fifo_stat.empty;
	assign pop  = load && b_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= b_done ? 2'd0 : step_q + 2'd1;
			end
			if (load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_data_q <= b_data;
			m_kind_q <= b_kind;
			m_last_q <= b_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

endmodule

// ===== sv/usb_data_packetizer_core.sv =====
`timescale 1ns / 1ps

// Transmit packetizer for USB low-speed data packets.
// The slave stream carries commands: tuser selects start, payload byte, host ack or
// received data PID, and tdata carries the operands. The master stream emits one packet
// byte per beat with its kind on tuser and end of packet on tlast.
// The front decodes each command beat, updates the transfer counters, data toggle and
// running CRC, and pushes a job into a four-entry queue. The back expands every job
// into one to three output beats (PID, payload, CRC bytes) through a registered output.
// An input beat is taken in any cycle the queue has room, so commands may arrive back
// to back. The first output beat of a command passes through a queue slot and then
// the output register. While tready is high the output delivers one beat per cycle;
// a payload byte that closes a packet yields three output beats and a zero-length
// packet three as well, so the output channel sets the sustained rate.
// When the receiver holds tready low, the output register holds its beat, the queue
// fills, and slave tready drops once four jobs are waiting.
// Reset clears all transfer state, empties the queue and loads the PID codes 0xC3 and
// 0x4B; the configuration port may rewrite them while the block is idle.
module usb_data_packetizer_core import usbpk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] transfer_length, [31:16] host_limit, [39:32] payload_byte,
	// [40] rx_was_data1, [47:41] zero
	input  logic [47:0] s_tdata,
	// [1:0] cmd
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] out_byte
	output logic [7:0]  m_tdata,
	// [1:0] byte_kind
	output logic [1:0]  m_tuser,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata
);

	fifo_stat_t fifo_stat;
	logic       push;
	job_t       push_job;
	logic       pop;
	job_t       head_job;

	// Front: command decode, transfer state and CRC.
	usbpk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.fifo_stat (fifo_stat),
		.push      (push),
		.push_job  (push_job)
	);

	// Queue of pending jobs that lets the front run ahead of a stalled receiver.
	usbpk_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.stat     (fifo_stat)
	);

	// Back: expands each job into output beats.
	usbpk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_job  (head_job),
		.fifo_stat (fifo_stat),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

`ifndef SYNTH
	// A full queue must stop the front from taking another command.
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_stat.full |-> !s_tready)
		else $error("input accepted while the job queue is full");

	// A rejection is a single zero byte that ends its packet.
	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_REJECT)) |-> (m_tlast && (m_tdata == 8'h00)))
		else $error("rejection beat malformed");

	// A PID never closes a packet.
	a_pid_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_PID)) |-> !m_tlast)
		else $error("PID beat marked as end of packet");

	// The queue is popped only while it holds a job.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_stat.empty)
		else $error("job queue popped while empty");
`endif

endmodule
